@@ rtl/lifo_pkg.sv @@
package lifo_pkg;

   localparam int DataWidth     = 32;
   localparam int FillWidth     = 5;
   localparam int DefaultDepth  = 16;
   localparam int MaxResults    = 16;
   localparam int DrainCntWidth = $clog2(MaxResults);

   typedef enum logic [1:0] {
      REQ_PUSH   = 2'd0,
      REQ_POP    = 2'd1,
      REQ_DRAIN  = 2'd2,
      REQ_BINARY = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SHIFT_HOLD,
      SHIFT_PUSH,
      SHIFT_POP
   } shift_op_type;

   typedef struct packed {
      shift_op_type          op;
      logic [DataWidth-1:0]  word;
   } shift_ctl_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_DRAIN,
      FSM_BINARY
   } state_type;

endpackage

@@ rtl/bounded_lifo_stack_top.sv @@
// Bounded LIFO stack of DEPTH 32-bit words, built as a row of word cells that shift
// toward the bottom on a push and toward the top on a pop, so the top word always sits
// in the first cell. A push or pop request gives one response. A drain gives one
// response per stored word, one per unstalled cycle, top first, up to 16 per request,
// with last set on the final one; an empty drain gives one underflow response.
// A push binary stores one bit of the value per cycle, from the least significant bit
// up to the highest set bit (at least one), then gives one summary response; bits that
// find the stack full are dropped and reported as overflow. Requests are taken one at a
// time: a new request is accepted once the previous one has finished and the response
// register is free or being emptied. fill_level reports the low 5 bits of the count.
module bounded_lifo_stack_top #(
   parameter int DEPTH = lifo_pkg::DefaultDepth
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_type,
   input  logic [lifo_pkg::DataWidth-1:0]       req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [lifo_pkg::DataWidth-1:0]       rsp_data,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_last,
   output logic [lifo_pkg::FillWidth-1:0]       rsp_fill_level
);

   lifo_pkg::shift_ctl_type        shift_ctl;
   logic [lifo_pkg::DataWidth-1:0] cell_word [DEPTH];

   lifo_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .rsp_fill_level (rsp_fill_level),
      .top_word       (cell_word[0]),
      .shift_ctl      (shift_ctl)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [lifo_pkg::DataWidth-1:0] up_word;
      logic [lifo_pkg::DataWidth-1:0] down_word;

      if (i == 0) begin : g_first
         assign up_word = shift_ctl.word;
      end else begin : g_mid_up
         assign up_word = cell_word[i-1];
      end

      // The bottom cell keeps its own word on a pop; it is never read until rewritten.
      if (i == DEPTH - 1) begin : g_last
         assign down_word = cell_word[i];
      end else begin : g_mid_down
         assign down_word = cell_word[i+1];
      end

      lifo_cell u_cell (
         .clock     (clock),
         .op        (shift_ctl.op),
         .up_word   (up_word),
         .down_word (down_word),
         .word      (cell_word[i])
      );
   end

endmodule

@@ rtl/lifo_cell.sv @@
module lifo_cell (
   input  logic                                 clock,
   input  lifo_pkg::shift_op_type               op,
   input  logic [lifo_pkg::DataWidth-1:0]       up_word,
   input  logic [lifo_pkg::DataWidth-1:0]       down_word,
   output logic [lifo_pkg::DataWidth-1:0]       word
);

   logic [lifo_pkg::DataWidth-1:0] word_ff;
   logic [lifo_pkg::DataWidth-1:0] word_in;

   always_comb begin
      case (op)
         lifo_pkg::SHIFT_PUSH: word_in = up_word;
         lifo_pkg::SHIFT_POP:  word_in = down_word;
         default:              word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

@@ rtl/lifo_ctrl.sv @@
module lifo_ctrl #(
   parameter int DEPTH = lifo_pkg::DefaultDepth
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_type,
   input  logic [lifo_pkg::DataWidth-1:0]       req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [lifo_pkg::DataWidth-1:0]       rsp_data,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_last,
   output logic [lifo_pkg::FillWidth-1:0]       rsp_fill_level,
   input  logic [lifo_pkg::DataWidth-1:0]       top_word,
   output lifo_pkg::shift_ctl_type              shift_ctl
);

   localparam int CntWidth = $clog2(DEPTH + 1);

   lifo_pkg::state_type state_ff, state_in;

   logic [CntWidth-1:0]                count_ff, count_in;
   logic [lifo_pkg::DrainCntWidth-1:0] drained_ff, drained_in;
   logic [lifo_pkg::DataWidth-1:0]     bits_ff, bits_in;
   logic                               dropped_ff, dropped_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [lifo_pkg::DataWidth-1:0]     rsp_data_ff, rsp_data_in;
   lifo_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic [lifo_pkg::FillWidth-1:0]     rsp_fill_ff, rsp_fill_in;
   logic                               load;

   logic                               accept;
   logic                               out_free;
   logic                               full;
   logic                               empty;
   logic                               drain_last;
   logic                               bits_done;
   logic [CntWidth+lifo_pkg::FillWidth-1:0] count_ext;
   lifo_pkg::req_code_type             req_code;

   assign req_code   = lifo_pkg::req_code_type'(req_type);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == lifo_pkg::FSM_IDLE) && out_free;
   assign accept     = req_valid && req_ready;
   assign full       = count_ff == CntWidth'(DEPTH);
   assign empty      = count_ff == '0;
   assign drain_last = (count_ff == CntWidth'(1))
                    || (drained_ff == lifo_pkg::DrainCntWidth'(lifo_pkg::MaxResults - 1));
   // Push binary ends once the remaining bits above the current one are all zero.
   assign bits_done  = bits_ff[lifo_pkg::DataWidth-1:1] == '0;
   assign count_ext  = {{lifo_pkg::FillWidth{1'b0}}, count_in};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lifo_pkg::FSM_IDLE: begin
            if (accept && req_code == lifo_pkg::REQ_DRAIN && !empty) begin
               state_in = lifo_pkg::FSM_DRAIN;
            end else if (accept && req_code == lifo_pkg::REQ_BINARY) begin
               state_in = lifo_pkg::FSM_BINARY;
            end
         end
         lifo_pkg::FSM_DRAIN: begin
            if (out_free && drain_last) begin
               state_in = lifo_pkg::FSM_IDLE;
            end
         end
         lifo_pkg::FSM_BINARY: begin
            if (bits_done) begin
               state_in = lifo_pkg::FSM_IDLE;
            end
         end
         default: state_in = lifo_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      shift_ctl.op   = lifo_pkg::SHIFT_HOLD;
      shift_ctl.word = req_value;
      count_in       = count_ff;
      drained_in     = drained_ff;
      bits_in        = bits_ff;
      dropped_in     = dropped_ff;
      load           = 1'b0;
      rsp_data_in    = '0;
      rsp_status_in  = lifo_pkg::STAT_OK;
      rsp_last_in    = 1'b1;
      case (state_ff)
         lifo_pkg::FSM_IDLE: begin
            if (accept) begin
               case (req_code)
                  lifo_pkg::REQ_PUSH: begin
                     load = 1'b1;
                     if (full) begin
                        rsp_status_in = lifo_pkg::STAT_OVERFLOW;
                     end else begin
                        shift_ctl.op = lifo_pkg::SHIFT_PUSH;
                        count_in     = count_ff + 1'b1;
                     end
                  end
                  lifo_pkg::REQ_POP: begin
                     load = 1'b1;
                     if (empty) begin
                        rsp_status_in = lifo_pkg::STAT_UNDERFLOW;
                     end else begin
                        rsp_data_in  = top_word;
                        shift_ctl.op = lifo_pkg::SHIFT_POP;
                        count_in     = count_ff - 1'b1;
                     end
                  end
                  lifo_pkg::REQ_DRAIN: begin
                     drained_in = '0;
                     if (empty) begin
                        load          = 1'b1;
                        rsp_status_in = lifo_pkg::STAT_UNDERFLOW;
                     end
                  end
                  default: begin
                     bits_in    = req_value;
                     dropped_in = 1'b0;
                  end
               endcase
            end
         end
         lifo_pkg::FSM_DRAIN: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_data_in  = top_word;
               rsp_last_in  = drain_last;
               shift_ctl.op = lifo_pkg::SHIFT_POP;
               count_in     = count_ff - 1'b1;
               drained_in   = drained_ff + 1'b1;
            end
         end
         lifo_pkg::FSM_BINARY: begin
            shift_ctl.word = {{(lifo_pkg::DataWidth-1){1'b0}}, bits_ff[0]};
            if (full) begin
               dropped_in = 1'b1;
            end else begin
               shift_ctl.op = lifo_pkg::SHIFT_PUSH;
               count_in     = count_ff + 1'b1;
            end
            bits_in = bits_ff >> 1;
            // The output register is empty here: nothing was loaded since the request.
            if (bits_done) begin
               load = 1'b1;
               if (dropped_ff || full) begin
                  rsp_status_in = lifo_pkg::STAT_OVERFLOW;
               end
            end
         end
         default: begin
         end
      endcase
      rsp_fill_in  = count_ext[lifo_pkg::FillWidth-1:0];
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lifo_pkg::FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drained_ff <= drained_in;
      bits_ff    <= bits_in;
      dropped_ff <= dropped_in;
      if (load) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_fill_ff   <= rsp_fill_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_data_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_fill_level = rsp_fill_ff;

endmodule
